// ===== src/strict_priority_multi_fifo_macros.svh =====
// ---------------------------------------------------------------------------
// strict priority multi fifo assertion macros
// shared concurrent assertion shorthands, clocked on clk_i, reset on rst_ni
// ---------------------------------------------------------------------------
`ifndef STRICT_PRIORITY_MULTI_FIFO_MACROS_SVH
`define STRICT_PRIORITY_MULTI_FIFO_MACROS_SVH

// same-cycle implication
`define SPMF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/spmf_pkg.sv =====
// ---------------------------------------------------------------------------
// spmf_pkg
// shared types and constants of the strict priority multi fifo
// ---------------------------------------------------------------------------
package spmf_pkg;

  localparam int unsigned LEVEL_W  = 2;
  localparam int unsigned OUT_TAG_W = 32;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [1:0] {
    STAT_ENQ   = 2'd0,
    STAT_DEQ   = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_DROP  = 2'd3
  } status_e;

  typedef struct packed {
    logic               is_deq;
    logic               lvl_ok;
    logic [LEVEL_W-1:0] level;
  } cmd_t;

endpackage

// ===== src/spmf_front.sv =====
// ---------------------------------------------------------------------------
// spmf_front
// accepts items, classifies them and holds them in a two-entry command queue
// ---------------------------------------------------------------------------
module spmf_front #(
  parameter int unsigned LEVEL_COUNT = 4,
  parameter int unsigned TAG_BITS    = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic                            action_i,
  input  logic [spmf_pkg::LEVEL_W-1:0]    level_i,
  input  logic [spmf_pkg::OUT_TAG_W-1:0]  tag_i,
  output logic                            cmd_valid_o,
  input  logic                            cmd_pop_i,
  output spmf_pkg::cmd_t                  cmd_o,
  output logic [TAG_BITS-1:0]             cmd_tag_o
);
  import spmf_pkg::*;

  cmd_t                cmd_q [2];
  logic [TAG_BITS-1:0] tag_q [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          cnt_q;
  logic                wr_en, rd_en;
  cmd_t                cmd_in;
  logic [63:0]         tag_wide;

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign wr_en       = push && !full;
  assign rd_en       = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = cmd_q[rd_ptr_q];
  assign cmd_tag_o   = tag_q[rd_ptr_q];

  // classify
  assign tag_wide      = 64'(tag_i);
  assign cmd_in.is_deq = action_i;
  assign cmd_in.lvl_ok = ({2'b00, level_i} < 4'(LEVEL_COUNT));
  assign cmd_in.level  = level_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cmd_q[wr_ptr_q] <= cmd_in;
      tag_q[wr_ptr_q] <= tag_wide[TAG_BITS-1:0];
    end
  end

endmodule

// ===== src/spmf_back.sv =====
// ---------------------------------------------------------------------------
// spmf_back
// per-level ring buffers in one tag memory, priority pick and result register
// ---------------------------------------------------------------------------
module spmf_back #(
  parameter int unsigned LEVEL_COUNT     = 4,
  parameter int unsigned SLOTS_PER_LEVEL = 16,
  parameter int unsigned TAG_BITS        = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  output logic                            cmd_pop_o,
  input  spmf_pkg::cmd_t                  cmd_i,
  input  logic [TAG_BITS-1:0]             cmd_tag_i,
  output logic                            res_valid_o,
  input  logic                            res_pop_i,
  output spmf_pkg::status_e               res_status_o,
  output logic [spmf_pkg::OUT_TAG_W-1:0]  res_tag_o,
  output logic [spmf_pkg::LEVEL_W-1:0]    res_level_o,
  output logic [spmf_pkg::COUNT_W-1:0]    res_total_o
);
  import spmf_pkg::*;

  localparam int unsigned DEPTH     = LEVEL_COUNT * SLOTS_PER_LEVEL;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned LVL_IDX_W = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int unsigned SLOT_W    = $clog2(SLOTS_PER_LEVEL);
  localparam int unsigned FILL_W    = $clog2(SLOTS_PER_LEVEL + 1);
  localparam int unsigned TOTAL_W   = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_READ = 2'b10
  } back_state_e;

  back_state_e          state_q, state_d;
  logic [FILL_W-1:0]    fill_q [LEVEL_COUNT];
  logic [FILL_W-1:0]    fill_d [LEVEL_COUNT];
  logic [SLOT_W-1:0]    head_q [LEVEL_COUNT];
  logic [SLOT_W-1:0]    head_d [LEVEL_COUNT];
  logic [TOTAL_W-1:0]   total_q, total_d;
  logic [LVL_IDX_W-1:0] pend_lvl_q, pend_lvl_d;

  logic                 res_valid_q, res_valid_d;
  status_e              res_status_q, res_status_d;
  logic [OUT_TAG_W-1:0] res_tag_q, res_tag_d;
  logic [LEVEL_W-1:0]   res_level_q, res_level_d;
  logic [COUNT_W-1:0]   res_total_q, res_total_d;

  logic [TAG_BITS-1:0]  mem [DEPTH];
  logic [TAG_BITS-1:0]  rd_data_q;
  logic                 mem_we, mem_re;
  logic [ADDR_W-1:0]    mem_addr;

  logic                 go;
  logic                 any_busy;
  logic [LVL_IDX_W-1:0] pick;
  logic [LVL_IDX_W-1:0] sel_lvl;
  logic [FILL_W-1:0]    sel_fill;
  logic [SLOT_W-1:0]    sel_head;
  logic                 sel_full;
  logic [SLOT_W:0]      tail_sum;
  logic [SLOT_W-1:0]    slot;
  logic [SLOT_W-1:0]    head_next;
  logic [63:0]          rd_wide;
  logic [15:0]          total_wide;

  // lowest busy level wins
  always_comb begin
    any_busy = 1'b0;
    pick     = '0;
    for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
      if (fill_q[i] != '0) begin
        any_busy = 1'b1;
        pick     = LVL_IDX_W'(i);
      end
    end
  end

  assign sel_lvl  = cmd_i.is_deq ? pick : LVL_IDX_W'(cmd_i.level);
  assign sel_fill = fill_q[sel_lvl];
  assign sel_head = head_q[sel_lvl];
  assign sel_full = (sel_fill == FILL_W'(SLOTS_PER_LEVEL));

  // tail slot, head plus fill wrapped once
  assign tail_sum  = {1'b0, sel_head} + (SLOT_W + 1)'(sel_fill);
  assign head_next = (sel_head == SLOT_W'(SLOTS_PER_LEVEL - 1)) ? '0 : sel_head + 1'b1;

  always_comb begin
    if (cmd_i.is_deq) begin
      slot = sel_head;
    end else if (tail_sum >= (SLOT_W + 1)'(SLOTS_PER_LEVEL)) begin
      slot = SLOT_W'(tail_sum - (SLOT_W + 1)'(SLOTS_PER_LEVEL));
    end else begin
      slot = tail_sum[SLOT_W-1:0];
    end
  end

  assign mem_addr = ADDR_W'(sel_lvl) * ADDR_W'(SLOTS_PER_LEVEL) + ADDR_W'(slot);
  assign go       = (state_q == BK_IDLE) && cmd_valid_i && (!res_valid_q || res_pop_i);
  assign cmd_pop_o = go;
  assign rd_wide  = 64'(rd_data_q);

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    head_d       = head_q;
    total_d      = total_q;
    pend_lvl_d   = pend_lvl_q;
    res_valid_d  = res_valid_q && !res_pop_i;
    res_status_d = res_status_q;
    res_tag_d    = res_tag_q;
    res_level_d  = res_level_q;
    res_total_d  = res_total_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    total_wide   = 16'(total_q);

    case (state_q)
      BK_IDLE: begin
        if (go) begin
          res_tag_d   = '0;
          res_level_d = '0;
          if (!cmd_i.is_deq) begin
            res_valid_d = 1'b1;
            if (!cmd_i.lvl_ok || sel_full) begin
              res_status_d = STAT_DROP;
            end else begin
              mem_we          = 1'b1;
              fill_d[sel_lvl] = sel_fill + 1'b1;
              total_d         = total_q + 1'b1;
              res_status_d    = STAT_ENQ;
            end
          end else if (!any_busy) begin
            res_valid_d  = 1'b1;
            res_status_d = STAT_EMPTY;
          end else begin
            mem_re          = 1'b1;
            head_d[sel_lvl] = head_next;
            fill_d[sel_lvl] = sel_fill - 1'b1;
            total_d         = total_q - 1'b1;
            pend_lvl_d      = sel_lvl;
            state_d         = BK_READ;
          end
          total_wide  = 16'(total_d);
          res_total_d = total_wide[COUNT_W-1:0];
        end
      end
      BK_READ: begin
        res_valid_d  = 1'b1;
        res_status_d = STAT_DEQ;
        res_tag_d    = rd_wide[OUT_TAG_W-1:0];
        res_level_d  = LEVEL_W'(pend_lvl_q);
        res_total_d  = total_wide[COUNT_W-1:0];
        state_d      = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      fill_q      <= '{default: '0};
      head_q      <= '{default: '0};
      total_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      head_q      <= head_d;
      total_q     <= total_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_lvl_q   <= pend_lvl_d;
    res_status_q <= res_status_d;
    res_tag_q    <= res_tag_d;
    res_level_q  <= res_level_d;
    res_total_q  <= res_total_d;
  end

  // tag memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= cmd_tag_i;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_addr];
    end
  end

  assign res_valid_o  = res_valid_q;
  assign res_status_o = res_status_q;
  assign res_tag_o    = res_tag_q;
  assign res_level_o  = res_level_q;
  assign res_total_o  = res_total_q;

endmodule

// ===== src/strict_priority_multi_fifo.sv =====
// ---------------------------------------------------------------------------
// strict_priority_multi_fifo
// strict priority queue of LEVEL_COUNT fifo levels, level 0 most urgent
// ---------------------------------------------------------------------------
// channel   direction  handshake          payload
// item      in         push / full        action_i, level_i, tag_i
// result    out        empty / pop        status_o, out_tag_o, served_level_o,
//                                         total_count_o
//
// an item passes a two-entry command queue, then the back end: an enqueue, a
// drop or an empty report goes straight to the result register, a served
// dequeue passes the BK_READ state first, for the registered tag memory read.
// the back end starts an item only once the result register is free or being
// popped; the command queue keeps taking items meanwhile.
// no clearing pass after reset; level fill counts guard every memory read.
// ---------------------------------------------------------------------------
`include "strict_priority_multi_fifo_macros.svh"

module strict_priority_multi_fifo #(
  parameter int unsigned LEVEL_COUNT     = 4,
  parameter int unsigned SLOTS_PER_LEVEL = 16,
  parameter int unsigned TAG_BITS        = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic                            action_i,
  input  logic [spmf_pkg::LEVEL_W-1:0]    level_i,
  input  logic [spmf_pkg::OUT_TAG_W-1:0]  tag_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [1:0]                      status_o,
  output logic [spmf_pkg::OUT_TAG_W-1:0]  out_tag_o,
  output logic [spmf_pkg::LEVEL_W-1:0]    served_level_o,
  output logic [spmf_pkg::COUNT_W-1:0]    total_count_o
);
  import spmf_pkg::*;

  logic                cmd_valid;
  logic                cmd_pop;
  cmd_t                cmd;
  logic [TAG_BITS-1:0] cmd_tag;
  logic                res_valid;
  status_e             res_status;

  spmf_front #(
    .LEVEL_COUNT (LEVEL_COUNT),
    .TAG_BITS    (TAG_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .action_i    (action_i),
    .level_i     (level_i),
    .tag_i       (tag_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_tag_o   (cmd_tag)
  );

  spmf_back #(
    .LEVEL_COUNT     (LEVEL_COUNT),
    .SLOTS_PER_LEVEL (SLOTS_PER_LEVEL),
    .TAG_BITS        (TAG_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_pop_o    (cmd_pop),
    .cmd_i        (cmd),
    .cmd_tag_i    (cmd_tag),
    .res_valid_o  (res_valid),
    .res_pop_i    (pop && !empty),
    .res_status_o (res_status),
    .res_tag_o    (out_tag_o),
    .res_level_o  (served_level_o),
    .res_total_o  (total_count_o)
  );

  assign empty    = !res_valid;
  assign status_o = res_status;

  `SPMF_ASSERT_NOW(a_take_needs_slot, cmd_pop, empty || pop, "back end took an item with the result slot occupied")
  `SPMF_ASSERT_NOW(a_zero_fields, !empty && (status_o != STAT_DEQ), (out_tag_o == '0) && (served_level_o == '0), "non-dequeue result carries tag or level")
  `SPMF_ASSERT_NOW(a_empty_count, !empty && (status_o == STAT_EMPTY), total_count_o == '0, "empty report with entries held")
  `SPMF_ASSERT_NEXT(a_take_consumes, cmd_pop && !(push && !full) && $past(full), !full, "command queue stayed full after a take")

endmodule

// ===== tb/strict_priority_multi_fifo_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// strict_priority_multi_fifo_checker
// watches the item and result channels, keeps its own four-level priority
// queue state, and compares every result transfer with the oldest prediction
// ---------------------------------------------------------------------------
module strict_priority_multi_fifo_checker #(
  parameter int unsigned LEVELS = 4,
  parameter int unsigned SLOTS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  input  logic                           full,
  input  logic                           action_i,
  input  logic [spmf_pkg::LEVEL_W-1:0]   level_i,
  input  logic [spmf_pkg::OUT_TAG_W-1:0] tag_i,
  input  logic                           empty,
  input  logic                           pop,
  input  logic [1:0]                     status_o,
  input  logic [spmf_pkg::OUT_TAG_W-1:0] out_tag_o,
  input  logic [spmf_pkg::LEVEL_W-1:0]   served_level_o,
  input  logic [spmf_pkg::COUNT_W-1:0]   total_count_o,
  output int                             error_count_o,
  output int                             pending_o
);
  import spmf_pkg::*;

  typedef logic [LEVEL_W-1:0] lvl_t;

  typedef struct {
    status_e              status;
    logic [OUT_TAG_W-1:0] tag;
    lvl_t                 level;
    logic [COUNT_W-1:0]   count;
  } queue_result_t;

  logic [OUT_TAG_W-1:0] slot_tags [LEVELS][SLOTS];
  logic [3:0]           head_idx  [LEVELS];
  logic [4:0]           fill_cnt  [LEVELS];
  logic [COUNT_W-1:0]   held_total;

  queue_result_t awaited_results[$];

  initial begin
    error_count_o = 0;
    pending_o     = 0;
  end

  function automatic queue_result_t serve_request(input logic act, input lvl_t lvl,
                                                  input logic [OUT_TAG_W-1:0] tag);
    queue_result_t res;
    logic          found;
    logic [3:0]    slot;
    res.status = STAT_ENQ;
    res.tag    = '0;
    res.level  = '0;
    found      = 1'b0;
    if (!act) begin
      if (fill_cnt[lvl] >= SLOTS) begin
        res.status = STAT_DROP;
      end else begin
        slot = head_idx[lvl] + fill_cnt[lvl][3:0];
        slot_tags[lvl][slot] = tag;
        fill_cnt[lvl] = fill_cnt[lvl] + 1'b1;
        held_total = held_total + 1'b1;
      end
    end else begin
      res.status = STAT_EMPTY;
      for (int i = 0; i < LEVELS; i++) begin
        if (!found && fill_cnt[i] != 0) begin
          found       = 1'b1;
          slot        = head_idx[i];
          res.status  = STAT_DEQ;
          res.tag     = slot_tags[i][slot];
          res.level   = lvl_t'(i);
          head_idx[i] = slot + 1'b1;
          fill_cnt[i] = fill_cnt[i] - 1'b1;
          held_total  = held_total - 1'b1;
        end
      end
    end
    res.count = held_total;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t exp_res;
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_idx[i] = '0;
        fill_cnt[i] = '0;
      end
      held_total = '0;
      awaited_results.delete();
    end else begin
      // result transfer first: it can never belong to an item taken at this edge
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected: status %0d tag %h",
                   $time, status_o, out_tag_o);
          error_count_o++;
        end else begin
          exp_res = awaited_results.pop_front();
          if (status_o !== exp_res.status) begin
            $display("%0t: status expected %0d (%s) got %0d", $time, exp_res.status,
                     exp_res.status.name(), status_o);
            error_count_o++;
          end
          if (out_tag_o !== exp_res.tag) begin
            $display("%0t: out_tag expected %h got %h", $time, exp_res.tag, out_tag_o);
            error_count_o++;
          end
          if (served_level_o !== exp_res.level) begin
            $display("%0t: served_level expected %0d got %0d", $time, exp_res.level,
                     served_level_o);
            error_count_o++;
          end
          if (total_count_o !== exp_res.count) begin
            $display("%0t: total_count expected %0d got %0d", $time, exp_res.count,
                     total_count_o);
            error_count_o++;
          end
        end
      end
      if (push && !full) begin
        awaited_results.push_back(serve_request(action_i, level_i, tag_i));
      end
    end
    pending_o = awaited_results.size();
  end

endmodule

// ===== tb/strict_priority_multi_fifo_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// strict_priority_multi_fifo_tb
// drives enqueue and dequeue items into the priority queue through a short
// directed sequence and bursts of random fill and drain traffic, with random
// gaps on the item side and stalls on the result side; the checker judges
// ---------------------------------------------------------------------------
module strict_priority_multi_fifo_tb;
  import spmf_pkg::*;

  localparam int unsigned LEVELS      = 4;
  localparam int unsigned SLOTS       = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 485;
  localparam logic        OP_ENQ      = 1'b0;
  localparam logic        OP_DEQ      = 1'b1;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 push           = 1'b0;
  logic                 action_i       = 1'b0;
  logic [LEVEL_W-1:0]   level_i        = '0;
  logic [OUT_TAG_W-1:0] tag_i          = '0;
  logic                 pop            = 1'b0;
  logic                 full;
  logic                 empty;
  logic [1:0]           status_o;
  logic [OUT_TAG_W-1:0] out_tag_o;
  logic [LEVEL_W-1:0]   served_level_o;
  logic [COUNT_W-1:0]   total_count_o;

  int error_cnt;
  int pending_cnt;
  int idle_pct  = 0;
  int stall_pct = 0;
  int cycle_cnt = 0;

  strict_priority_multi_fifo #(
    .LEVEL_COUNT    (LEVELS),
    .SLOTS_PER_LEVEL(SLOTS),
    .TAG_BITS       (32)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .level_i       (level_i),
    .tag_i         (tag_i),
    .empty         (empty),
    .pop           (pop),
    .status_o      (status_o),
    .out_tag_o     (out_tag_o),
    .served_level_o(served_level_o),
    .total_count_o (total_count_o)
  );

  strict_priority_multi_fifo_checker #(
    .LEVELS(LEVELS),
    .SLOTS (SLOTS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .level_i       (level_i),
    .tag_i         (tag_i),
    .empty         (empty),
    .pop           (pop),
    .status_o      (status_o),
    .out_tag_o     (out_tag_o),
    .served_level_o(served_level_o),
    .total_count_o (total_count_o),
    .error_count_o (error_cnt),
    .pending_o     (pending_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("strict_priority_multi_fifo test failed");
      $finish;
    end
  end

  // result side stalls
  always @(posedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  task automatic send_op(input logic act, input logic [LEVEL_W-1:0] lvl,
                         input logic [OUT_TAG_W-1:0] tag);
    while ($urandom_range(99) < idle_pct) begin
      push     <= 1'b0;
      action_i <= 1'($urandom_range(1));
      level_i  <= LEVEL_W'($urandom_range(LEVELS - 1));
      tag_i    <= $urandom;
      @(posedge clk_i);
    end
    push     <= 1'b1;
    action_i <= act;
    level_i  <= lvl;
    tag_i    <= tag;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // bursts that lean towards filling, towards draining or stay balanced, often on one level
  task automatic run_traffic(input int n_items);
    int          sent;
    int          burst_len;
    int          enq_pct;
    logic        focused;
    logic [LEVEL_W-1:0] focus_lvl;
    logic        act;
    logic [LEVEL_W-1:0] lvl;
    sent = 0;
    while (sent < n_items) begin
      burst_len = $urandom_range(40, 8);
      case ($urandom_range(2))
        0: enq_pct = 85;
        1: enq_pct = 50;
        default: enq_pct = 15;
      endcase
      focused   = 1'($urandom_range(1));
      focus_lvl = LEVEL_W'($urandom_range(LEVELS - 1));
      for (int k = 0; k < burst_len && sent < n_items; k++) begin
        act = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
        lvl = (focused && $urandom_range(9) != 0) ? focus_lvl :
              LEVEL_W'($urandom_range(LEVELS - 1));
        send_op(act, lvl, $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty dequeue, tag patterns on every level, priority drain
    send_op(OP_DEQ, 2'd3, 32'hFFFF_FFFF);
    send_op(OP_ENQ, 2'd3, 32'h0000_0000);
    send_op(OP_ENQ, 2'd2, 32'hFFFF_FFFF);
    send_op(OP_ENQ, 2'd1, 32'h5555_5555);
    send_op(OP_ENQ, 2'd0, 32'hAAAA_AAAA);
    send_op(OP_ENQ, 2'd0, 32'hFFFF_FFFF);
    send_op(OP_ENQ, 2'd3, 32'h8000_0001);
    for (int k = 0; k < 6; k++) send_op(OP_DEQ, 2'(k), 32'h0000_0000);
    send_op(OP_DEQ, 2'd0, 32'h0000_0000);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 52; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 52; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      run_traffic(PHASE_ITEMS);
    end
    push <= 1'b0;

    while (pending_cnt != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_cnt == 0 && pending_cnt == 0) begin
      $display("strict_priority_multi_fifo test passed");
    end else begin
      $display("strict_priority_multi_fifo test failed");
    end
    $finish;
  end

endmodule
